// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, suspended while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, suspended while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked around reset.
`define ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pipct_pkg.sv
// Package with shared constants and types of the point-in-polygon crossing test.
package pipct_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int TOL_W           = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

    localparam logic [1:0] LOC_OUTSIDE  = 2'd0;
    localparam logic [1:0] LOC_INSIDE   = 2'd1;
    localparam logic [1:0] LOC_BOUNDARY = 2'd2;

    typedef enum logic [1:0] {
        KIND_SKIP  = 2'd0,
        KIND_BOUND = 2'd1,
        KIND_TEST  = 2'd2
    } t_edge_kind;

    typedef struct packed {
        t_edge_kind kind;
        logic       last;
        logic       dy_neg;
        logic       low_end;
    } t_edge_ctl;

endpackage

// File: rtl/pipct_front.sv
// Front end: bounds checks and edge classification, with the differences for the back end.
module pipct_front #(
    parameter int COORD_WIDTH = pipct_pkg::COORD_WIDTH_DEF
) (
    input  logic signed [COORD_WIDTH-1:0]    i_query_x,
    input  logic signed [COORD_WIDTH-1:0]    i_query_y,
    input  logic signed [COORD_WIDTH-1:0]    i_edge_start_x,
    input  logic signed [COORD_WIDTH-1:0]    i_edge_start_y,
    input  logic signed [COORD_WIDTH-1:0]    i_edge_end_x,
    input  logic signed [COORD_WIDTH-1:0]    i_edge_end_y,
    input  logic                             i_last_edge,
    input  logic [pipct_pkg::TOL_W-1:0]      i_tolerance,
    output pipct_pkg::t_edge_ctl             o_ctl,
    output logic signed [COORD_WIDTH:0]      o_dist_y,
    output logic signed [COORD_WIDTH:0]      o_edge_dx,
    output logic signed [COORD_WIDTH:0]      o_dist_x,
    output logic signed [COORD_WIDTH:0]      o_edge_dy,
    output logic [COORD_WIDTH-1:0]           o_span_y
);

    localparam int W = COORD_WIDTH;

    logic signed [W:0]   dy_fwd;
    logic signed [W:0]   dy_rev;
    logic signed [W:0]   ym_start;
    logic signed [W:0]   ym_end;
    logic signed [W-1:0] min_x;
    logic signed [W-1:0] max_x;
    logic signed [W-1:0] min_y;
    logic signed [W-1:0] max_y;
    logic [W:0]          tol_ext;
    logic [W:0]          span_ext;
    logic [W:0]          above_min;
    logic                dy_neg;
    logic                off_band;
    logic                horiz;

    assign dy_fwd   = {i_edge_end_y[W-1], i_edge_end_y} - {i_edge_start_y[W-1], i_edge_start_y};
    assign dy_rev   = {i_edge_start_y[W-1], i_edge_start_y} - {i_edge_end_y[W-1], i_edge_end_y};
    assign ym_start = {i_query_y[W-1], i_query_y} - {i_edge_start_y[W-1], i_edge_start_y};
    assign ym_end   = {i_query_y[W-1], i_query_y} - {i_edge_end_y[W-1], i_edge_end_y};
    assign dy_neg   = dy_fwd[W];

    assign min_x = (i_edge_start_x < i_edge_end_x) ? i_edge_start_x : i_edge_end_x;
    assign max_x = (i_edge_start_x < i_edge_end_x) ? i_edge_end_x : i_edge_start_x;
    assign min_y = dy_neg ? i_edge_end_y : i_edge_start_y;
    assign max_y = dy_neg ? i_edge_start_y : i_edge_end_y;

    assign tol_ext   = {{(W + 1 - pipct_pkg::TOL_W){1'b0}}, i_tolerance};
    assign span_ext  = dy_neg ? {1'b0, dy_rev[W-1:0]} : {1'b0, dy_fwd[W-1:0]};
    assign above_min = dy_neg ? ym_end : ym_start;

    assign off_band = (i_query_y < min_y) || (i_query_y > max_y) || (i_query_x < min_x);
    assign horiz    = (span_ext < tol_ext) || (dy_fwd == '0);

    always_comb begin
        o_ctl.last    = i_last_edge;
        o_ctl.dy_neg  = dy_neg;
        o_ctl.low_end = (above_min < tol_ext);
        if (off_band) begin
            o_ctl.kind = pipct_pkg::KIND_SKIP;
        end else if (horiz) begin
            o_ctl.kind = (i_query_x <= max_x) ? pipct_pkg::KIND_BOUND : pipct_pkg::KIND_SKIP;
        end else begin
            o_ctl.kind = pipct_pkg::KIND_TEST;
        end
    end

    assign o_dist_y  = ym_start;
    assign o_edge_dx = {i_edge_end_x[W-1], i_edge_end_x} - {i_edge_start_x[W-1], i_edge_start_x};
    assign o_dist_x  = {i_query_x[W-1], i_query_x} - {i_edge_start_x[W-1], i_edge_start_x};
    assign o_edge_dy = dy_fwd;
    assign o_span_y  = span_ext[W-1:0];

endmodule

// File: rtl/pipct_queue.sv
// Short register queue that decouples the front end from the back end.
module pipct_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = pipct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/pipct_back.sv
// Back end: intercept products, tolerance compare, crossing parity and result register.
module pipct_back #(
    parameter int COORD_WIDTH = pipct_pkg::COORD_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_pop,
    input  pipct_pkg::t_edge_ctl             i_ctl,
    input  logic signed [COORD_WIDTH:0]      i_dist_y,
    input  logic signed [COORD_WIDTH:0]      i_edge_dx,
    input  logic signed [COORD_WIDTH:0]      i_dist_x,
    input  logic signed [COORD_WIDTH:0]      i_edge_dy,
    input  logic [COORD_WIDTH-1:0]           i_span_y,
    input  logic [pipct_pkg::TOL_W-1:0]      i_tolerance,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [1:0]                       o_location
);

    localparam int W     = COORD_WIDTH;
    localparam int PROD_W = 2 * W + 2;
    localparam int DIFF_W = 2 * W + 3;
    localparam int SUM_W  = 2 * W + 4;
    localparam int LIM_W  = W + pipct_pkg::TOL_W;

    logic                        advance;
    logic                        r_s1_valid;
    pipct_pkg::t_edge_ctl        r_s1_ctl;
    logic signed [PROD_W-1:0]    r_s1_prod_a;
    logic signed [PROD_W-1:0]    r_s1_prod_b;
    logic [LIM_W-1:0]            r_s1_lim;
    logic                        r_s2_valid;
    pipct_pkg::t_edge_ctl        r_s2_ctl;
    logic signed [DIFF_W-1:0]    r_s2_diff;
    logic [LIM_W-1:0]            r_s2_lim;
    logic signed [DIFF_W-1:0]    n_s2_diff;
    logic signed [SUM_W-1:0]     lim_sum;
    logic                        diff_pos;
    logic                        near_edge;
    logic                        hit_boundary;
    logic                        hit_cross;
    logic                        r_parity;
    logic                        r_boundary;
    logic                        n_parity;
    logic                        n_boundary;
    logic                        r_out_valid;
    logic [1:0]                  r_location;

    assign advance = !(r_out_valid && i_stall);
    assign o_pop   = advance && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_ctl    <= i_ctl;
            r_s1_prod_a <= PROD_W'(i_dist_y) * PROD_W'(i_edge_dx);
            r_s1_prod_b <= PROD_W'(i_dist_x) * PROD_W'(i_edge_dy);
            r_s1_lim    <= LIM_W'(i_tolerance) * LIM_W'(i_span_y);
            r_s2_ctl    <= r_s1_ctl;
            r_s2_diff   <= n_s2_diff;
            r_s2_lim    <= r_s1_lim;
        end
    end

    // The sign of the difference is flipped for a downward edge so that a positive
    // value always means the intercept lies right of the point.
    always_comb begin
        if (r_s1_ctl.dy_neg) begin
            n_s2_diff = DIFF_W'(r_s1_prod_b) - DIFF_W'(r_s1_prod_a);
        end else begin
            n_s2_diff = DIFF_W'(r_s1_prod_a) - DIFF_W'(r_s1_prod_b);
        end
    end

    assign lim_sum   = SUM_W'(r_s2_diff) + $signed(SUM_W'({1'b0, r_s2_lim}));
    assign diff_pos  = !r_s2_diff[DIFF_W-1] && (r_s2_diff != '0);
    assign near_edge = !lim_sum[SUM_W-1] && (lim_sum != '0);

    always_comb begin
        hit_boundary = 1'b0;
        hit_cross    = 1'b0;
        case (r_s2_ctl.kind)
            pipct_pkg::KIND_BOUND: begin
                hit_boundary = 1'b1;
            end
            pipct_pkg::KIND_TEST: begin
                if (!diff_pos) begin
                    if (near_edge) begin
                        hit_boundary = 1'b1;
                    end else if (!r_s2_ctl.low_end) begin
                        hit_cross = 1'b1;
                    end
                end
            end
            default: begin
                hit_boundary = 1'b0;
                hit_cross    = 1'b0;
            end
        endcase
    end

    assign n_parity   = r_parity ^ hit_cross;
    assign n_boundary = r_boundary | hit_boundary;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity    <= 1'b0;
            r_boundary  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s2_valid && r_s2_ctl.last;
            if (r_s2_valid) begin
                if (r_s2_ctl.last) begin
                    r_parity   <= 1'b0;
                    r_boundary <= 1'b0;
                end else begin
                    r_parity   <= n_parity;
                    r_boundary <= n_boundary;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_s2_valid && r_s2_ctl.last) begin
            if (n_boundary) begin
                r_location <= pipct_pkg::LOC_BOUNDARY;
            end else if (n_parity) begin
                r_location <= pipct_pkg::LOC_INSIDE;
            end else begin
                r_location <= pipct_pkg::LOC_OUTSIDE;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_location = r_location;

endmodule

// File: rtl/point_in_polygon_crossing_test_unit.sv
// Top level of the point-in-polygon crossing test: tolerance register, front end, queue, back end.
//
//   Channel   Direction  Handshake                 Payload
//   edge in   input      i_valid / o_stall         query point, edge endpoints, last edge
//   result    output     o_valid / i_stall         location
//   config    input      i_cfg_valid / o_cfg_ready tolerance
//
// One edge is accepted per cycle as long as the edge queue has room.
// A result follows its closing edge through the queue, then through the product and
// difference stages of the back end, whose compare feeds the result register.
// Reset is synchronous and active low; it empties the queue and pipeline, clears the
// parity and boundary flags and sets the tolerance to one.
// A stalled result holds the back end; the queue then fills and raises o_stall.
module point_in_polygon_crossing_test_unit #(
    parameter int COORD_WIDTH = pipct_pkg::COORD_WIDTH_DEF,
    parameter int QUEUE_DEPTH = pipct_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_query_x,
    input  logic signed [COORD_WIDTH-1:0] i_query_y,
    input  logic signed [COORD_WIDTH-1:0] i_edge_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_edge_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_edge_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_edge_end_y,
    input  logic                          i_last_edge,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_location,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pipct_pkg::TOL_W-1:0]   i_cfg_data
);

    localparam int W      = COORD_WIDTH;
    localparam int CTL_W  = $bits(pipct_pkg::t_edge_ctl);
    localparam int DATA_W = CTL_W + 4 * (W + 1) + W;

    logic [pipct_pkg::TOL_W-1:0] r_tolerance;
    pipct_pkg::t_edge_ctl        fe_ctl;
    logic signed [W:0]           fe_dist_y;
    logic signed [W:0]           fe_edge_dx;
    logic signed [W:0]           fe_dist_x;
    logic signed [W:0]           fe_edge_dy;
    logic [W-1:0]                fe_span_y;
    logic [DATA_W-1:0]           q_in_data;
    logic [DATA_W-1:0]           q_out_data;
    logic                        q_full;
    logic                        q_valid;
    logic                        be_pop;
    pipct_pkg::t_edge_ctl        be_ctl;
    logic signed [W:0]           be_dist_y;
    logic signed [W:0]           be_edge_dx;
    logic signed [W:0]           be_dist_x;
    logic signed [W:0]           be_edge_dy;
    logic [W-1:0]                be_span_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= pipct_pkg::TOL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tolerance <= i_cfg_data;
        end
    end

    pipct_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .i_edge_start_x (i_edge_start_x),
        .i_edge_start_y (i_edge_start_y),
        .i_edge_end_x   (i_edge_end_x),
        .i_edge_end_y   (i_edge_end_y),
        .i_last_edge    (i_last_edge),
        .i_tolerance    (r_tolerance),
        .o_ctl          (fe_ctl),
        .o_dist_y       (fe_dist_y),
        .o_edge_dx      (fe_edge_dx),
        .o_dist_x       (fe_dist_x),
        .o_edge_dy      (fe_edge_dy),
        .o_span_y       (fe_span_y)
    );

    assign q_in_data = {fe_ctl, fe_dist_y, fe_edge_dx, fe_dist_x, fe_edge_dy, fe_span_y};

    pipct_queue #(
        .DATA_W (DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (q_in_data),
        .o_full  (q_full),
        .i_pop   (be_pop),
        .o_valid (q_valid),
        .o_data  (q_out_data)
    );

    assign o_stall = q_full;
    assign {be_ctl, be_dist_y, be_edge_dx, be_dist_x, be_edge_dy, be_span_y} = q_out_data;

    pipct_back #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_pop       (be_pop),
        .i_ctl       (be_ctl),
        .i_dist_y    (be_dist_y),
        .i_edge_dx   (be_edge_dx),
        .i_dist_x    (be_dist_x),
        .i_edge_dy   (be_edge_dy),
        .i_span_y    (be_span_y),
        .i_tolerance (r_tolerance),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_location  (o_location)
    );

endmodule

// File: rtl/pipct_checker.sv
// Port-level assertions for the point-in-polygon crossing test, bound to the top level.
`include "assert_macros.svh"

module pipct_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [1:0] o_location
);

    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_location), "stalled result changed")
    `ASSERT_IMPLY(a_location_code, i_clk, i_rst_n, o_valid, (o_location == pipct_pkg::LOC_OUTSIDE) || (o_location == pipct_pkg::LOC_INSIDE) || (o_location == pipct_pkg::LOC_BOUNDARY), "location code out of range")
    `ASSERT_ALWAYS(a_reset_no_result, i_clk, !i_rst_n, !o_valid, "result shown right after reset")
    `ASSERT_ALWAYS(a_reset_no_stall, i_clk, !i_rst_n, !o_stall, "input stalled right after reset")

endmodule

bind point_in_polygon_crossing_test_unit pipct_checker u_checker (.*);
